### sv/profile_count_and_consensus_defines.svh
// ----------------------------------------------------------------------------
// profile_count_and_consensus_defines.svh
// assertion macros used by the checker file of the profile counter block
// ----------------------------------------------------------------------------
`ifndef PROFILE_COUNT_AND_CONSENSUS_DEFINES_SVH
`define PROFILE_COUNT_AND_CONSENSUS_DEFINES_SVH

// clocked check, switched off while reset is low
`define PCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked check that also holds while reset is low
`define PCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// types, constants and helpers of the profile counter and consensus block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int CTR_NUM     = 6;
  localparam int COUNT_W     = 32;
  localparam int ADDR_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = CTR_NUM * COUNT_W;

  localparam int OP_W        = 2;
  localparam int COLUMN_W    = 12;
  localparam int SYMBOL_W    = 8;
  localparam int ABUND_W     = 24;
  localparam int LEN_W       = 13;
  localparam int CENSOR_W    = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [LEN_W-1:0] ALN_LEN_RESET = LEN_W'(4096);

  // ascii codes
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_U    = 8'h55;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    OP_ACC  = 2'd0,
    OP_CONS = 2'd1,
    OP_CLR  = 2'd2
  } pcc_op_e;

  typedef enum logic [1:0] {
    CFG_ALN_LEN      = 2'd0,
    CFG_LEFT_CENSOR  = 2'd1,
    CFG_RIGHT_CENSOR = 2'd2
  } pcc_cfg_e;

  typedef enum logic [2:0] {
    CTR_A   = 3'd0,
    CTR_C   = 3'd1,
    CTR_G   = 3'd2,
    CTR_T   = 3'd3,
    CTR_N   = 3'd4,
    CTR_GAP = 3'd5
  } pcc_ctr_e;

  // classified work for the back end
  typedef enum logic [1:0] {
    KIND_ACC,
    KIND_CLR,
    KIND_CONS,
    KIND_CENS
  } pcc_kind_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOAD,
    BK_CMP,
    BK_GAP,
    BK_OUT
  } pcc_bk_state_e;

  typedef struct packed {
    pcc_kind_e            kind;
    logic [ADDR_W-1:0]    column;
    pcc_ctr_e             ctr;
    logic [ABUND_W-1:0]   abundance;
  } pcc_item_t;

  typedef struct packed {
    logic     hit;
    pcc_ctr_e ctr;
  } pcc_dec_t;

  // case-blind symbol to counter mapping
  function automatic pcc_dec_t decode_symbol(logic [SYMBOL_W-1:0] sym);
    logic [7:0] c;
    pcc_dec_t   d;
    c = sym;
    if (c inside {[CH_LO_A:CH_LO_Z]}) begin
      c = c - CASE_OFFSET;
    end
    d.hit = 1'b1;
    d.ctr = CTR_A;
    case (c) inside
      CH_A: d.ctr = CTR_A;
      CH_C: d.ctr = CTR_C;
      CH_G: d.ctr = CTR_G;
      CH_T, CH_U: d.ctr = CTR_T;
      // R Y S W K M B D H V N
      8'h52, 8'h59, 8'h53, 8'h57, 8'h4B, 8'h4D,
      8'h42, 8'h44, 8'h48, 8'h56, CH_N: d.ctr = CTR_N;
      CH_DASH: d.ctr = CTR_GAP;
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] ctr_letter(pcc_ctr_e k);
    logic [7:0] l;
    case (k)
      CTR_A:   l = CH_A;
      CTR_C:   l = CH_C;
      CTR_G:   l = CH_G;
      CTR_T:   l = CH_T;
      CTR_N:   l = CH_N;
      default: l = CH_DASH;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

### sv/pcc_ram.sv
// ----------------------------------------------------------------------------
// pcc_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/pcc_queue.sv
// ----------------------------------------------------------------------------
// pcc_queue
// short fifo of classified items between front end and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcc_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire pcc_pkg::pcc_item_t item_i,
  input  wire logic              pop_i,
  output pcc_pkg::pcc_item_t     head_o,
  output logic                   empty_o,
  output logic                   full_o
);
  import pcc_pkg::*;

  pcc_item_t          entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_o  = entries_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### sv/pcc_front.sv
// ----------------------------------------------------------------------------
// pcc_front
// configuration registers, input acceptance and item classification
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcc_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [pcc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [pcc_pkg::OP_W-1:0]          op_i,
  input  wire logic [pcc_pkg::COLUMN_W-1:0]      column_i,
  input  wire logic [pcc_pkg::SYMBOL_W-1:0]      symbol_i,
  input  wire logic [pcc_pkg::ABUND_W-1:0]       abundance_i,
  input  wire logic                              q_full_i,
  input  wire logic                              clear_busy_i,
  output logic                                   q_push_o,
  output pcc_pkg::pcc_item_t                     q_item_o
);
  import pcc_pkg::*;

  logic [LEN_W-1:0]    aln_len_q;
  logic [CENSOR_W-1:0] left_cen_q;
  logic [CENSOR_W-1:0] right_cen_q;

  pcc_dec_t            dec;
  logic                in_range;
  logic                censored;
  logic [LEN_W-1:0]    col_plus_right;
  logic                keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aln_len_q   <= ALN_LEN_RESET;
      left_cen_q  <= '0;
      right_cen_q <= '0;
    end else if (cfg_we_i) begin
      case (pcc_cfg_e'(cfg_idx_i))
        CFG_ALN_LEN:      aln_len_q   <= cfg_wdata_i[LEN_W-1:0];
        CFG_LEFT_CENSOR:  left_cen_q  <= cfg_wdata_i[CENSOR_W-1:0];
        CFG_RIGHT_CENSOR: right_cen_q <= cfg_wdata_i[CENSOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full_i && !clear_busy_i;

  always_comb begin
    dec            = decode_symbol(symbol_i);
    in_range       = (int'(column_i) < MAX_COLUMNS);
    col_plus_right = LEN_W'(column_i) + LEN_W'(right_cen_q);
    censored       = !in_range || (column_i < left_cen_q) || (col_plus_right >= aln_len_q);

    q_item_o.kind      = KIND_ACC;
    q_item_o.column    = ADDR_W'(column_i);
    q_item_o.ctr       = dec.ctr;
    q_item_o.abundance = abundance_i;
    keep               = 1'b0;

    case (pcc_op_e'(op_i))
      OP_ACC: begin
        keep = dec.hit && in_range;
      end
      OP_CLR: begin
        q_item_o.kind = KIND_CLR;
        keep          = in_range;
      end
      OP_CONS: begin
        q_item_o.kind = censored ? KIND_CENS : KIND_CONS;
        keep          = 1'b1;
      end
      default: keep = 1'b0;
    endcase

    // items with no effect are taken and dropped here
    q_push_o = in_valid_i && in_ready_o && keep;
  end

endmodule

`default_nettype wire

### sv/pcc_back.sv
// ----------------------------------------------------------------------------
// pcc_back
// counter store sequencer: clearing pass, updates, consensus and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pcc_pkg::pcc_item_t head_i,
  input  wire logic               q_empty_i,
  output logic                    q_pop_o,
  output logic                    clear_busy_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic [7:0]              m_aln_o,
  output logic                    m_cv_o,
  output logic [7:0]              m_cons_o
);
  import pcc_pkg::*;

  localparam int SUM_W = ((COUNT_W > ABUND_W) ? COUNT_W : ABUND_W) + 1;

  pcc_bk_state_e       state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  pcc_item_t           cur_q, cur_d;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic [ROW_W-1:0]    ram_rdata;

  logic [COUNT_W-1:0]  b1_val_q, b1_val_d, b2_val_q, b2_val_d;
  pcc_ctr_e            b1_ctr_q, b1_ctr_d, b2_ctr_q, b2_ctr_d;
  logic [COUNT_W-1:0]  n_q, n_d, gap_q, gap_d;
  logic [COUNT_W-1:0]  best_q, best_d;
  logic [7:0]          sym_q, sym_d;
  logic [7:0]          res_aln_q, res_aln_d, res_cons_q, res_cons_d;
  logic                res_cv_q, res_cv_d;
  logic                m_valid_q, m_valid_d;
  logic [7:0]          m_aln_q, m_aln_d, m_cons_q, m_cons_d;
  logic                m_cv_q, m_cv_d;

  logic [COUNT_W-1:0]  cnt_a, cnt_c, cnt_g, cnt_t;
  logic [COUNT_W-1:0]  old_cnt, new_cnt;
  logic [SUM_W-1:0]    sum;

  pcc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_COLUMNS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_i.column),
    .rdata_o (ram_rdata)
  );

  assign clear_busy_o = (state_q == BK_CLEAR);
  assign m_valid_o    = m_valid_q;
  assign m_aln_o      = m_aln_q;
  assign m_cv_o       = m_cv_q;
  assign m_cons_o     = m_cons_q;

  // counter fields of the row just read
  assign cnt_a   = ram_rdata[int'(CTR_A) * COUNT_W +: COUNT_W];
  assign cnt_c   = ram_rdata[int'(CTR_C) * COUNT_W +: COUNT_W];
  assign cnt_g   = ram_rdata[int'(CTR_G) * COUNT_W +: COUNT_W];
  assign cnt_t   = ram_rdata[int'(CTR_T) * COUNT_W +: COUNT_W];
  assign old_cnt = ram_rdata[int'(cur_q.ctr) * COUNT_W +: COUNT_W];

  // saturating update
  assign sum     = SUM_W'(old_cnt) + SUM_W'(cur_q.abundance);
  assign new_cnt = (|sum[SUM_W-1:COUNT_W]) ? '1 : sum[COUNT_W-1:0];

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cur_d      = cur_q;
    b1_val_d   = b1_val_q;
    b1_ctr_d   = b1_ctr_q;
    b2_val_d   = b2_val_q;
    b2_ctr_d   = b2_ctr_q;
    n_d        = n_q;
    gap_d      = gap_q;
    best_d     = best_q;
    sym_d      = sym_q;
    res_aln_d  = res_aln_q;
    res_cv_d   = res_cv_q;
    res_cons_d = res_cons_q;
    m_valid_d  = m_valid_q && !m_ready_i;
    m_aln_d    = m_aln_q;
    m_cv_d     = m_cv_q;
    m_cons_d   = m_cons_q;
    q_pop_o    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = head_i.column;
    ram_wdata  = '0;

    case (state_q)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(MAX_COLUMNS - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = head_i;
          case (head_i.kind)
            KIND_CLR: begin
              ram_we = 1'b1;
            end
            KIND_CENS: begin
              res_aln_d  = CH_PLUS;
              res_cv_d   = 1'b0;
              res_cons_d = '0;
              state_d    = BK_OUT;
            end
            default: state_d = BK_LOAD;
          endcase
        end
      end
      BK_LOAD: begin
        if (cur_q.kind == KIND_ACC) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q.column;
          ram_wdata = ram_rdata;
          ram_wdata[int'(cur_q.ctr) * COUNT_W +: COUNT_W] = new_cnt;
          state_d   = BK_IDLE;
        end else begin
          // first of the largest: a later counter wins only when strictly greater
          b1_val_d = (cnt_c > cnt_a) ? cnt_c : cnt_a;
          b1_ctr_d = (cnt_c > cnt_a) ? CTR_C : CTR_A;
          b2_val_d = (cnt_t > cnt_g) ? cnt_t : cnt_g;
          b2_ctr_d = (cnt_t > cnt_g) ? CTR_T : CTR_G;
          n_d      = ram_rdata[int'(CTR_N) * COUNT_W +: COUNT_W];
          gap_d    = ram_rdata[int'(CTR_GAP) * COUNT_W +: COUNT_W];
          state_d  = BK_CMP;
        end
      end
      BK_CMP: begin
        if (b2_val_q > b1_val_q) begin
          best_d = b2_val_q;
          sym_d  = ctr_letter(b2_ctr_q);
        end else begin
          best_d = b1_val_q;
          sym_d  = ctr_letter(b1_ctr_q);
        end
        if ((b1_val_q == '0) && (b2_val_q == '0)) begin
          if (n_q != '0) begin
            best_d = n_q;
            sym_d  = CH_N;
          end else begin
            sym_d  = CH_DASH;
          end
        end
        state_d = BK_GAP;
      end
      BK_GAP: begin
        if (best_q >= gap_q) begin
          res_aln_d  = sym_q;
          res_cv_d   = 1'b1;
          res_cons_d = sym_q;
        end else begin
          res_aln_d  = CH_DASH;
          res_cv_d   = 1'b0;
          res_cons_d = '0;
        end
        state_d = BK_OUT;
      end
      BK_OUT: begin
        if (!m_valid_q || m_ready_i) begin
          m_valid_d = 1'b1;
          m_aln_d   = res_aln_q;
          m_cv_d    = res_cv_q;
          m_cons_d  = res_cons_q;
          state_d   = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    b1_val_q   <= b1_val_d;
    b1_ctr_q   <= b1_ctr_d;
    b2_val_q   <= b2_val_d;
    b2_ctr_q   <= b2_ctr_d;
    n_q        <= n_d;
    gap_q      <= gap_d;
    best_q     <= best_d;
    sym_q      <= sym_d;
    res_aln_q  <= res_aln_d;
    res_cv_q   <= res_cv_d;
    res_cons_q <= res_cons_d;
    m_aln_q    <= m_aln_d;
    m_cv_q     <= m_cv_d;
    m_cons_q   <= m_cons_d;
  end

endmodule

`default_nettype wire

### sv/profile_count_and_consensus.sv
// ----------------------------------------------------------------------------
// profile_count_and_consensus
// per-column nucleotide profile counters with majority consensus readout
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: op; tdata: column, symbol, abundance
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser: cons_valid; tdata: aln_symbol, cons_symbol
// cfg       in         cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//
// an accumulate reads and rewrites its 192-bit column row, written back in the load state; a clear
// is written straight from idle, a consensus runs load, cmp, gap and out, a censored one goes to out
// after reset a clearing pass writes all 4096 rows, one per cycle, with s_axis_tready low
// a 4-entry queue lets the input side keep taking transactions while the back end works
// a finished result waits in the output register; the back end only halts on a second
// result while that register is still full
//
`timescale 1ns / 1ps
`default_nettype none

module profile_count_and_consensus (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [pcc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [pcc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [pcc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // column, symbol, abundance
  input  wire logic [pcc_pkg::OP_W-1:0]             s_axis_tuser,  // op
  // result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [pcc_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,  // aln_symbol, cons_symbol
  output logic                                      m_axis_tuser   // cons_valid
);
  import pcc_pkg::*;

  localparam int SYM_LO = COLUMN_W;
  localparam int AB_LO  = COLUMN_W + SYMBOL_W;

  pcc_item_t q_item;
  pcc_item_t q_head;
  logic      q_push, q_pop, q_empty, q_full;
  logic      clear_busy;
  logic [7:0] res_aln, res_cons;
  logic       res_cv;

  // front end: config registers and classification of each incoming transaction
  pcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .column_i     (s_axis_tdata[COLUMN_W-1:0]),
    .symbol_i     (s_axis_tdata[SYM_LO +: SYMBOL_W]),
    .abundance_i  (s_axis_tdata[AB_LO +: ABUND_W]),
    .q_full_i     (q_full),
    .clear_busy_i (clear_busy),
    .q_push_o     (q_push),
    .q_item_o     (q_item)
  );

  // decoupling queue
  pcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back end: counter memory, consensus compare chain and output register
  pcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .clear_busy_o (clear_busy),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_aln_o      (res_aln),
    .m_cv_o       (res_cv),
    .m_cons_o     (res_cons)
  );

  assign m_axis_tdata = {res_cons, res_aln};
  assign m_axis_tuser = res_cv;

endmodule

`default_nettype wire

### sv/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// port-level checks of the profile counter block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "profile_count_and_consensus_defines.svh"

module pcc_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tready,
  input  wire logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic [pcc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  wire logic                              m_axis_tuser
);
  import pcc_pkg::*;

  // a stalled result keeps its content
  `PCC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a symbol that joins the consensus is repeated in cons_symbol
  `PCC_ASSERT(a_cons_match, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:8] == m_axis_tdata[7:0], "cons_symbol differs from aln_symbol")

  // a symbol that does not join is a gap or a censor mark with a zero cons_symbol
  `PCC_ASSERT(a_no_join, m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[7:0] == CH_PLUS || m_axis_tdata[7:0] == CH_DASH) && m_axis_tdata[15:8] == 8'h00, "bad non-joining result")

  // nothing moves once reset has been seen at an edge
  `PCC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid && !s_axis_tready, "activity during reset")

endmodule

bind profile_count_and_consensus pcc_checker u_pcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the column profile counters and their consensus call
// ----------------------------------------------------------------------------
// a scoreboard class keeps its own copy of the per-column counters and
// registers, predicts every consensus call when its request transaction is
// accepted and compares each returned call field by field. directed
// transactions cover ties, gap wins, ambiguity codes, censoring and the unused
// op; random phases run under several register settings, with a saturating
// run on one column, a long output hold-off and a stretch with no idling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import pcc_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 64;       // well above queue depth times the slowest back-end pass
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;   // clearing pass plus slowest run, many times over
  localparam logic [ABUND_W-1:0] ABUND_MAX = '1;
  localparam logic [OP_W-1:0]    OP_UNUSED = 2'd3;

  // one consensus call as it leaves the block
  typedef struct packed {
    logic [7:0] aln_symbol;
    logic       cons_valid;
    logic [7:0] cons_symbol;
  } col_call_t;

  // --------------------------------------------------------------------------
  // scoreboard: counter store, registers and calls still due
  // --------------------------------------------------------------------------
  class consensus_scoreboard;
    bit [COUNT_W-1:0] counts [MAX_COLUMNS][CTR_NUM];
    int unsigned      aln_len;
    int unsigned      left_cen;
    int unsigned      right_cen;
    col_call_t        calls_due[$];
    int               errors;

    function new();
      aln_len   = 4096;
      left_cen  = 0;
      right_cen = 0;
      errors    = 0;
    endfunction

    function void set_reg(pcc_cfg_e idx, int unsigned val);
      case (idx)
        CFG_ALN_LEN:      aln_len   = val;
        CFG_LEFT_CENSOR:  left_cen  = val;
        CFG_RIGHT_CENSOR: right_cen = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return calls_due.size();
    endfunction

    // case-blind symbol to counter slot, -1 when the byte is not counted
    function int slot_of(logic [7:0] sym);
      logic [7:0] u;
      int         slot;
      u = sym;
      if (u >= CH_LO_A && u <= CH_LO_Z) begin
        u = u - CASE_OFFSET;
      end
      case (u)
        CH_A:       slot = CTR_A;
        CH_C:       slot = CTR_C;
        CH_G:       slot = CTR_G;
        CH_T, CH_U: slot = CTR_T;
        "R", "Y", "S", "W", "K", "M", "B", "D", "H", "V", CH_N: slot = CTR_N;
        CH_DASH:    slot = CTR_GAP;
        default:    slot = -1;
      endcase
      return slot;
    endfunction

    function col_call_t call_column(int unsigned col);
      logic [7:0]       letters [4];
      col_call_t        c;
      bit [COUNT_W-1:0] best;
      logic [7:0]       winner;
      letters = '{CH_A, CH_C, CH_G, CH_T};
      // inside the left or right censor or outside the alignment
      if (col < left_cen || col + right_cen >= aln_len) begin
        c.aln_symbol  = CH_PLUS;
        c.cons_valid  = 1'b0;
        c.cons_symbol = 8'h00;
        return c;
      end
      // first of the largest nucleotide counts, then ambiguity
      best   = counts[col][CTR_A];
      winner = CH_A;
      for (int k = CTR_C; k <= CTR_T; k++) begin
        if (counts[col][k] > best) begin
          best   = counts[col][k];
          winner = letters[k];
        end
      end
      if (best == 0) begin
        if (counts[col][CTR_N] != 0) begin
          best   = counts[col][CTR_N];
          winner = CH_N;
        end else begin
          winner = CH_DASH;
        end
      end
      // ties with the gap count go to the winner
      if (best >= counts[col][CTR_GAP]) begin
        c.aln_symbol  = winner;
        c.cons_valid  = 1'b1;
        c.cons_symbol = winner;
      end else begin
        c.aln_symbol  = CH_DASH;
        c.cons_valid  = 1'b0;
        c.cons_symbol = 8'h00;
      end
      return c;
    endfunction

    function void note_input(logic [1:0] op, logic [COLUMN_W-1:0] col,
                             logic [SYMBOL_W-1:0] sym, logic [ABUND_W-1:0] ab);
      int                 slot;
      logic [COUNT_W:0]   sum;
      case (op)
        OP_ACC: begin
          slot = slot_of(sym);
          if (slot >= 0) begin
            sum = {1'b0, counts[col][slot]} + ab;
            counts[col][slot] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
          end
        end
        OP_CLR: begin
          for (int k = 0; k < CTR_NUM; k++) counts[col][k] = '0;
        end
        OP_CONS: calls_due.push_back(call_column(col));
        default: ;  // unused op
      endcase
    endfunction

    function void check_result(col_call_t got);
      col_call_t want;
      if (calls_due.size() == 0) begin
        $display("%0t: unexpected consensus call %h", $time, got);
        errors++;
        return;
      end
      want = calls_due.pop_front();
      if (got.aln_symbol !== want.aln_symbol) begin
        $display("%0t: aln_symbol expected %h actual %h", $time,
                 want.aln_symbol, got.aln_symbol);
        errors++;
      end
      if (got.cons_valid !== want.cons_valid) begin
        $display("%0t: cons_valid expected %b actual %b", $time,
                 want.cons_valid, got.cons_valid);
        errors++;
      end
      if (got.cons_symbol !== want.cons_symbol) begin
        $display("%0t: cons_symbol expected %h actual %h", $time,
                 want.cons_symbol, got.cons_symbol);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // column, symbol, abundance
  logic [OP_W-1:0]        s_axis_tuser  = '0;  // op

  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // aln_symbol, cons_symbol
  logic                   m_axis_tuser;        // cons_valid

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  profile_count_and_consensus u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  consensus_scoreboard sb = new();

  // idle rates in percent, changed per phase by the stimulus process
  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 15;
  bit          hold_req    = 1'b0;
  int unsigned cycles      = 0;

  // --------------------------------------------------------------------------
  // monitor: both transaction kinds are sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // a call can never leave in the cycle its request is taken, so check first
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result('{aln_symbol:  m_axis_tdata[7:0],
                          cons_valid:  m_axis_tuser,
                          cons_symbol: m_axis_tdata[15:8]});
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_input(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[19:12],
                      s_axis_tdata[43:20]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("profile_count_and_consensus verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random back-pressure, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        // counted here so the sender keeps pushing calls into a full block
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------
  // called and left at a falling edge; tvalid stays high into the next call
  task automatic send_item(logic [1:0] op, logic [COLUMN_W-1:0] col,
                           logic [SYMBOL_W-1:0] sym, logic [ABUND_W-1:0] ab);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, ab, sym, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // all three registers on consecutive cycles, input valid held low
  task automatic write_config(int unsigned len, int unsigned lcen, int unsigned rcen);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b1;
    cfg_idx_i     <= CFG_ALN_LEN;
    cfg_wdata_i   <= CFG_DATA_W'(len);
    sb.set_reg(CFG_ALN_LEN, len);
    @(negedge clk_i);
    cfg_idx_i     <= CFG_LEFT_CENSOR;
    cfg_wdata_i   <= CFG_DATA_W'(lcen);
    sb.set_reg(CFG_LEFT_CENSOR, lcen);
    @(negedge clk_i);
    cfg_idx_i     <= CFG_RIGHT_CENSOR;
    cfg_wdata_i   <= CFG_DATA_W'(rcen);
    sb.set_reg(CFG_RIGHT_CENSOR, rcen);
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
  endtask

  // every call back, then room for accumulates and clears still in flight
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // random transactions around a moving column window; unused ops not counted
  task automatic run_random(int unsigned n);
    string               alphabet;
    int unsigned         done;
    int unsigned         r;
    int unsigned         base;
    logic [1:0]          op;
    logic [COLUMN_W-1:0] col;
    logic [SYMBOL_W-1:0] sym;
    logic [ABUND_W-1:0]  ab;
    alphabet = "ACGTUacgtuRYSWKMBDHVNryswkmbdhvn-";
    done     = 0;
    base     = 0;
    while (done < n) begin
      if (done % 64 == 0) begin
        base = $urandom_range(1) ? $urandom_range(sb.aln_len - 1) : $urandom_range(4095);
      end
      r  = $urandom_range(99);
      op = (r < 58) ? OP_ACC : (r < 83) ? OP_CONS : (r < 91) ? OP_CLR : OP_UNUSED;
      col = ($urandom_range(99) < 88) ? COLUMN_W'(base + $urandom_range(15))
                                      : COLUMN_W'($urandom_range(4095));
      sym = ($urandom_range(99) < 75) ? alphabet[$urandom_range(alphabet.len() - 1)]
                                      : SYMBOL_W'($urandom_range(255));
      r  = $urandom_range(99);
      ab = (r < 55) ? ABUND_W'($urandom_range(3)) :
           (r < 85) ? ABUND_W'($urandom_range(ABUND_MAX)) : ABUND_MAX;
      send_item(op, col, sym, ab);
      if (op != OP_UNUSED) done++;
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // short alignment with censoring on both sides; writes overlap the clearing pass
    write_config(20, 2, 3);

    // untouched column calls a gap that still joins
    send_item(OP_CONS, 12'd5, 8'h00, '0);
    // tie between A and C goes to A
    send_item(OP_ACC,  12'd5, "a", 24'd3);
    send_item(OP_ACC,  12'd5, "C", 24'd3);
    send_item(OP_CONS, 12'd5, 8'h00, '0);
    // gap equal to the winner keeps the winner
    send_item(OP_ACC,  12'd5, CH_DASH, 24'd3);
    send_item(OP_CONS, 12'd5, 8'h00, '0);
    // gap above the winner
    send_item(OP_ACC,  12'd5, CH_DASH, 24'd1);
    send_item(OP_CONS, 12'd5, 8'h00, '0);
    // ambiguity only, tied with gap; zero abundance leaves counts alone
    send_item(OP_ACC,  12'd6, "n", 24'd7);
    send_item(OP_ACC,  12'd6, CH_DASH, 24'd7);
    send_item(OP_ACC,  12'd6, "u", 24'd0);
    send_item(OP_CONS, 12'd6, 8'h00, '0);
    // G before T on a tie, ambiguity loses to nucleotides, junk bytes ignored
    send_item(OP_ACC,  12'd7, "R", 24'd1);
    send_item(OP_ACC,  12'd7, "g", 24'd2);
    send_item(OP_ACC,  12'd7, "t", 24'd2);
    send_item(OP_ACC,  12'd7, 8'hFF, ABUND_MAX);
    send_item(OP_CONS, 12'd7, 8'h00, '0);
    // clear, then the unused op
    send_item(OP_CLR,  12'd7, 8'h00, '0);
    send_item(OP_CONS, 12'd7, 8'h00, '0);
    send_item(OP_UNUSED, 12'd8, "A", ABUND_MAX);
    // censor edges and a column past the alignment, which still accumulates
    send_item(OP_ACC,  12'd4095, "T", ABUND_MAX);
    send_item(OP_CONS, 12'd1, 8'h00, '0);
    send_item(OP_CONS, 12'd2, 8'h00, '0);
    send_item(OP_CONS, 12'd16, 8'h00, '0);
    send_item(OP_CONS, 12'd17, 8'h00, '0);
    send_item(OP_CONS, 12'd4095, 8'h00, '0);
    drain();

    // full alignment, no censoring
    write_config(4096, 0, 0);
    run_random(200);
    // long output hold-off while calls keep arriving
    tx_idle_pct = 0;
    hold_req    = 1'b1;
    for (int i = 0; i < 40; i++) send_item(OP_CONS, COLUMN_W'($urandom_range(4095)), 8'h00, '0);
    tx_idle_pct = 15;
    // one column driven into saturation, then its gap count saturated as well
    send_item(OP_CLR, 12'd9, 8'h00, '0);
    for (int i = 0; i < 260; i++) begin
      send_item(OP_ACC, 12'd9, (i % 2) ? "a" : "A", ABUND_MAX);
      if (i % 20 == 0) send_item(OP_CONS, 12'd9, 8'h00, '0);
    end
    for (int i = 0; i < 270; i++) begin
      if (i % 30 == 0) send_item(OP_CONS, 12'd9, 8'h00, '0);
      send_item(OP_ACC, 12'd9, CH_DASH, ABUND_MAX);
    end
    send_item(OP_CONS, 12'd9, 8'h00, '0);
    drain();

    // single column alignment
    write_config(1, 0, 0);
    run_random(100);
    drain();

    // small alignment with no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_config(64, 4, 5);
    run_random(200);
    drain();
    tx_idle_pct = 15;
    rx_idle_pct = 15;

    // censors at their maximum: everything reported as outside
    write_config(4096, 4095, 4095);
    run_random(100);
    drain();

    write_config(300, 10, 20);
    run_random(200);
    drain();

    begin
      int unsigned len;
      len = $urandom_range(4096, 1);
      write_config(len, $urandom_range(len - 1), $urandom_range(len - 1));
    end
    run_random(200);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("profile_count_and_consensus verification clean");
    end else begin
      $display("profile_count_and_consensus verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/pcc_pkg.sv
sv/pcc_ram.sv
sv/pcc_queue.sv
sv/pcc_front.sv
sv/pcc_back.sv
sv/profile_count_and_consensus.sv
sv/pcc_checker.sv
test/tb_top.sv
